### design/lru_sector_cache_controller_top_defines.svh
// Assertion macros for the cache controller top.
`ifndef LRU_SECTOR_CACHE_CONTROLLER_TOP_DEFINES_SVH
`define LRU_SECTOR_CACHE_CONTROLLER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define LSCC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define LSCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LSCC_ASSERT_SAME(label, ante, cons, msg)
`define LSCC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### design/lscc_pkg.sv
`default_nettype none
package lscc_pkg;

    localparam int NUM_SLOTS    = 32;
    localparam int SLOT_W       = $clog2(NUM_SLOTS);
    localparam int NUM_OWNERS   = 16;
    localparam int OWNER_W      = 4;
    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
    localparam int SECTOR_W     = 32;
    localparam int SIZE_W       = 48;
    localparam int RES_SLOT_W   = 6;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    localparam logic [1:0] CMD_MAP   = 2'd0;
    localparam logic [1:0] CMD_FLUSH = 2'd1;
    localparam logic [1:0] CMD_SIZE  = 2'd2;

    localparam logic [1:0] KIND_MAP   = 2'd0;
    localparam logic [1:0] KIND_WB    = 2'd1;
    localparam logic [1:0] KIND_SIZE  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    localparam logic [1:0] FILL_LEAVE = 2'd0;
    localparam logic [1:0] FILL_ZERO  = 2'd1;
    localparam logic [1:0] FILL_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [OWNER_W-1:0]  owner;
        logic [SECTOR_W-1:0] sector_index;
        logic                mark_dirty;
        logic                release_req;
        logic                write_back;
        logic [SIZE_W-1:0]   new_file_size;
    } in_item_t;

    typedef struct packed {
        logic [1:0]            kind;
        logic [RES_SLOT_W-1:0] slot;
        logic                  hit;
        logic [1:0]            fill;
        logic [OWNER_W-1:0]    req_owner;
        logic [SECTOR_W-1:0]   req_sector;
        logic [SIZE_W-1:0]     req_length;
        logic                  last;
    } out_item_t;

    typedef struct packed {
        logic              in_range;
        logic              past_ext;
        logic [SIZE_W-1:0] len;
        logic [SIZE_W-1:0] ext_next;
    } wb_res_t;

    function automatic out_item_t make_result(
        input logic [1:0]          kind,
        input logic [SLOT_W-1:0]   slot,
        input logic                hit,
        input logic [1:0]          fill,
        input logic [OWNER_W-1:0]  owner,
        input logic [SECTOR_W-1:0] sector,
        input logic [SIZE_W-1:0]   len,
        input logic                last
    );
        out_item_t r;
        r.kind       = kind;
        r.slot       = {{(RES_SLOT_W - SLOT_W){1'b0}}, slot};
        r.hit        = hit;
        r.fill       = fill;
        r.req_owner  = owner;
        r.req_sector = sector;
        r.req_length = len;
        r.last       = last;
        return r;
    endfunction

endpackage
`default_nettype wire

### design/lru_sector_cache_controller_top.sv
// Map: recency walk, one slot a cycle, then victim and fill steps.
// Flush: walk up to the first free slot, then a reorder sweep over all slots.
// Set size gives no word; each result word is registered in the step that makes it.
// Every word is shown for one cycle on strobe; the receiver cannot stall it.
// Asynchronous active-low reset empties all slots and restores identity recency order.
`default_nettype none
`include "lru_sector_cache_controller_top_defines.svh"
// The recency order is held as a list from rank to slot. A map walks it from
// the most recent end, stops at a hit or at the first free slot, and otherwise
// takes the least recent slot. All offset arithmetic goes through one shared
// unit, which serves the victim write-back, the fill decision and each flush
// step in turn. A flush rebuilds the order in a sweep: kept slots, then the
// slots that were already free, then the slots freed by this flush.
module lru_sector_cache_controller_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire lscc_pkg::in_item_t item,
    output logic                    strobe,
    output lscc_pkg::out_item_t     result
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_MAP_WALK,
        S_MAP_VICT,
        S_MAP_FILL,
        S_FL_WALK,
        S_FL_ORDER
    } state_t;

    localparam int SW = lscc_pkg::SLOT_W;

    state_t                              state_reg;
    lscc_pkg::in_item_t                  item_reg;
    logic [lscc_pkg::NUM_SLOTS-1:0]      valid_reg;
    logic [lscc_pkg::NUM_SLOTS-1:0]      dirty_reg;
    logic [lscc_pkg::OWNER_W-1:0]        owner_reg  [lscc_pkg::NUM_SLOTS];
    logic [lscc_pkg::SECTOR_W-1:0]       sector_reg [lscc_pkg::NUM_SLOTS];
    logic [SW-1:0]                       order_reg  [lscc_pkg::NUM_SLOTS];
    logic [SW-1:0]                       kept_reg   [lscc_pkg::NUM_SLOTS];
    logic [SW-1:0]                       freed_reg  [lscc_pkg::NUM_SLOTS];
    logic [lscc_pkg::SIZE_W-1:0]         fsize_reg  [lscc_pkg::NUM_OWNERS];
    logic [lscc_pkg::SIZE_W-1:0]         ext_reg    [lscc_pkg::NUM_OWNERS];
    logic [lscc_pkg::NUM_OWNERS-1:0]     open_reg;
    logic [SW-1:0]                       r_reg;
    logic [SW-1:0]                       sel_reg;
    logic [SW-1:0]                       pos_reg;
    logic                                hit_reg;
    logic [SW:0]                         kc_reg;
    logic [SW:0]                         fc_reg;
    logic [SW:0]                         nv_reg;
    logic                                strobe_reg;
    lscc_pkg::out_item_t                 result_reg;

    logic [SW-1:0]                       walk_c;
    logic                                walk_hit;
    logic [lscc_pkg::OWNER_W-1:0]        u_owner;
    logic [lscc_pkg::SECTOR_W-1:0]       u_sector;
    lscc_pkg::wb_res_t                   u_res;
    logic [SW+1:0]                       sum_pn;
    logic                                in_kept;
    logic                                in_free;
    logic [SW-1:0]                       sweep_val;
    logic                                accept;
    logic                                victim_wb;
    logic                                flush_mine;
    logic                                flush_move;

    assign busy   = (state_reg != S_IDLE);
    assign strobe = strobe_reg;
    assign result = result_reg;
    assign accept = start && !busy;

    always_comb
    begin
        walk_c   = order_reg[r_reg];
        walk_hit = (owner_reg[walk_c] == item_reg.owner)
                && (sector_reg[walk_c] == item_reg.sector_index);
        if (state_reg == S_MAP_VICT)
        begin
            u_owner  = owner_reg[sel_reg];
            u_sector = sector_reg[sel_reg];
        end
        else if (state_reg == S_FL_WALK)
        begin
            u_owner  = item_reg.owner;
            u_sector = sector_reg[walk_c];
        end
        else
        begin
            u_owner  = item_reg.owner;
            u_sector = item_reg.sector_index;
        end
        // Sweep position r_reg: kept slots, then the old free tail, then freed.
        sum_pn  = {2'b00, r_reg} + {1'b0, nv_reg};
        in_kept = {1'b0, r_reg} < kc_reg;
        in_free = sum_pn < ({1'b0, kc_reg} + (SW+2)'(lscc_pkg::NUM_SLOTS));
        if (in_kept)
            sweep_val = kept_reg[r_reg];
        else if (in_free)
            sweep_val = order_reg[sum_pn[SW-1:0] - kc_reg[SW-1:0]];
        else
            sweep_val = freed_reg[sum_pn[SW-1:0] - kc_reg[SW-1:0]];
        victim_wb  = !hit_reg && valid_reg[sel_reg] && dirty_reg[sel_reg] && u_res.in_range;
        flush_mine = owner_reg[walk_c] == item_reg.owner;
        flush_move = item_reg.release_req || !u_res.in_range;
    end

    lscc_wb_unit u_wb (
        .size   (fsize_reg[u_owner]),
        .sector (u_sector),
        .extent (ext_reg[u_owner]),
        .res    (u_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            valid_reg  <= '0;
            dirty_reg  <= '0;
            open_reg   <= '0;
            strobe_reg <= 1'b0;
            r_reg      <= '0;
            kc_reg     <= '0;
            fc_reg     <= '0;
            nv_reg     <= '0;
            for (int i = 0; i < lscc_pkg::NUM_SLOTS; i++)
            begin
                order_reg[i] <= i[SW-1:0];
            end
            for (int j = 0; j < lscc_pkg::NUM_OWNERS; j++)
            begin
                fsize_reg[j] <= '0;
                ext_reg[j]   <= '0;
            end
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        item_reg <= item;
                        r_reg    <= '0;
                        kc_reg   <= '0;
                        fc_reg   <= '0;
                        unique case (item.cmd)
                            lscc_pkg::CMD_MAP:
                            begin
                                state_reg <= S_MAP_WALK;
                            end
                            lscc_pkg::CMD_FLUSH:
                            begin
                                state_reg <= S_FL_WALK;
                                if (item.write_back && (fsize_reg[item.owner] != '0))
                                begin
                                    open_reg[item.owner] <= 1'b1;
                                    strobe_reg <= 1'b1;
                                    result_reg <= lscc_pkg::make_result(
                                        lscc_pkg::KIND_SIZE, '0, 1'b0, lscc_pkg::FILL_LEAVE,
                                        item.owner, '0, fsize_reg[item.owner], 1'b0);
                                end
                            end
                            lscc_pkg::CMD_SIZE:
                            begin
                                fsize_reg[item.owner] <= item.new_file_size;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_MAP_WALK:
                begin
                    sel_reg <= walk_c;
                    pos_reg <= r_reg;
                    hit_reg <= valid_reg[walk_c] && walk_hit;
                    if (!valid_reg[walk_c] || walk_hit || (r_reg == lscc_pkg::LAST_SLOT))
                        state_reg <= S_MAP_VICT;
                    else
                        r_reg <= r_reg + 1'b1;
                end
                S_MAP_VICT:
                begin
                    for (int i = 1; i < lscc_pkg::NUM_SLOTS; i++)
                    begin
                        if (i[SW-1:0] <= pos_reg)
                            order_reg[i] <= order_reg[i-1];
                    end
                    order_reg[0] <= sel_reg;
                    if (victim_wb)
                    begin
                        open_reg[u_owner] <= 1'b1;
                        ext_reg[u_owner]  <= u_res.ext_next;
                        strobe_reg <= 1'b1;
                        result_reg <= lscc_pkg::make_result(
                            lscc_pkg::KIND_WB, sel_reg, 1'b0, lscc_pkg::FILL_LEAVE,
                            u_owner, u_sector, u_res.len, 1'b0);
                    end
                    state_reg <= S_MAP_FILL;
                end
                S_MAP_FILL:
                begin
                    if (!hit_reg)
                    begin
                        valid_reg[sel_reg]  <= 1'b1;
                        owner_reg[sel_reg]  <= item_reg.owner;
                        sector_reg[sel_reg] <= item_reg.sector_index;
                        dirty_reg[sel_reg]  <= item_reg.mark_dirty;
                    end
                    else if (item_reg.mark_dirty)
                    begin
                        dirty_reg[sel_reg] <= 1'b1;
                    end
                    strobe_reg <= 1'b1;
                    result_reg <= lscc_pkg::make_result(
                        lscc_pkg::KIND_MAP, sel_reg, hit_reg,
                        (!hit_reg && open_reg[item_reg.owner] && u_res.in_range)
                            ? (u_res.past_ext ? lscc_pkg::FILL_ZERO : lscc_pkg::FILL_READ)
                            : lscc_pkg::FILL_LEAVE,
                        '0, '0, '0, 1'b1);
                    state_reg <= S_IDLE;
                end
                S_FL_WALK:
                begin
                    if (!valid_reg[walk_c])
                    begin
                        nv_reg    <= {1'b0, r_reg};
                        r_reg     <= '0;
                        state_reg <= S_FL_ORDER;
                    end
                    else
                    begin
                        if (flush_mine && u_res.in_range && item_reg.write_back
                            && dirty_reg[walk_c] && open_reg[item_reg.owner])
                        begin
                            ext_reg[item_reg.owner] <= u_res.ext_next;
                            strobe_reg <= 1'b1;
                            result_reg <= lscc_pkg::make_result(
                                lscc_pkg::KIND_WB, walk_c, 1'b0, lscc_pkg::FILL_LEAVE,
                                item_reg.owner, u_sector, u_res.len, 1'b0);
                        end
                        if (flush_mine && flush_move)
                        begin
                            freed_reg[fc_reg[SW-1:0]] <= walk_c;
                            fc_reg <= fc_reg + 1'b1;
                            valid_reg[walk_c] <= 1'b0;
                            dirty_reg[walk_c] <= 1'b0;
                        end
                        else
                        begin
                            kept_reg[kc_reg[SW-1:0]] <= walk_c;
                            kc_reg <= kc_reg + 1'b1;
                        end
                        if (r_reg == lscc_pkg::LAST_SLOT)
                        begin
                            nv_reg    <= (SW+1)'(lscc_pkg::NUM_SLOTS);
                            r_reg     <= '0;
                            state_reg <= S_FL_ORDER;
                        end
                        else
                        begin
                            r_reg <= r_reg + 1'b1;
                        end
                    end
                end
                S_FL_ORDER:
                begin
                    order_reg[r_reg] <= sweep_val;
                    if (r_reg == lscc_pkg::LAST_SLOT)
                    begin
                        strobe_reg <= 1'b1;
                        result_reg <= lscc_pkg::make_result(
                            lscc_pkg::KIND_DONE, '0, 1'b0, lscc_pkg::FILL_LEAVE,
                            item_reg.owner, '0, '0, 1'b1);
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        r_reg <= r_reg + 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    `LSCC_ASSERT_SAME(a_last_ends_item, strobe && result.last, !busy, "busy after last word")
    `LSCC_ASSERT_SAME(a_mid_word_busy, strobe && !result.last, busy, "non-final word while idle")
    `LSCC_ASSERT_SAME(a_map_is_last, strobe && (result.kind == lscc_pkg::KIND_MAP), result.last, "map word not final")
    `LSCC_ASSERT_SAME(a_hit_leaves, strobe && result.hit, result.fill == lscc_pkg::FILL_LEAVE, "hit with fill")
    `LSCC_ASSERT_NEXT(a_map_goes_busy, start && !busy && (item.cmd == lscc_pkg::CMD_MAP), busy, "map not started")

endmodule
`default_nettype wire

### design/lscc_wb_unit.sv
`default_nettype none
// Shared offset and length unit: sector offset, range check against the file
// size, clamped write-back length and the grown written extent.
module lscc_wb_unit (
    input  wire logic [lscc_pkg::SIZE_W-1:0]   size,
    input  wire logic [lscc_pkg::SECTOR_W-1:0] sector,
    input  wire logic [lscc_pkg::SIZE_W-1:0]   extent,
    output lscc_pkg::wb_res_t                  res
);
    logic [lscc_pkg::SIZE_W-1:0] off;
    logic [lscc_pkg::SIZE_W-1:0] diff;
    logic [lscc_pkg::SIZE_W-1:0] len;
    logic [lscc_pkg::SIZE_W-1:0] fin;

    always_comb
    begin
        off  = {{(lscc_pkg::SIZE_W - lscc_pkg::SECTOR_W - lscc_pkg::SECTOR_SHIFT){1'b0}},
                sector, {lscc_pkg::SECTOR_SHIFT{1'b0}}};
        diff = size - off;
        len  = (diff > lscc_pkg::SIZE_W'(lscc_pkg::SECTOR_BYTES))
             ? lscc_pkg::SIZE_W'(lscc_pkg::SECTOR_BYTES) : diff;
        fin  = off + len;
        res.in_range = size > off;
        res.past_ext = off >= extent;
        res.len      = len;
        res.ext_next = (fin > extent) ? fin : extent;
    end
endmodule
`default_nettype wire
